[rtl/pfr_pkg.sv]
//------------------------------------------------------------------------------
// pfr_pkg: shared types and constants for Pareto front ranking
// Population and objective sizes, sequencer states and the control group that
// drives the dominance compare unit.
//------------------------------------------------------------------------------
`default_nettype none
package pfr_pkg;
    localparam int POP_MAX     = 64;
    localparam int POP_IDX_W   = $clog2(POP_MAX);
    localparam int POP_CNT_W   = POP_IDX_W + 1;
    localparam int OBJ_MAX     = 8;
    localparam int OBJ_IDX_W   = $clog2(OBJ_MAX);
    localparam int OBJ_CNT_W   = OBJ_IDX_W + 1;
    localparam int OBJ_W       = 32;
    localparam int OBJ_ADDR_W  = POP_IDX_W + OBJ_IDX_W;
    localparam int RANK_W      = 6;
    localparam int CFG_W       = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

    typedef enum logic [7:0] {
        ST_LOAD     = 8'b0000_0001,
        ST_FILL     = 8'b0000_0010,
        ST_CMP      = 8'b0000_0100,
        ST_PEEL_RD  = 8'b0000_1000,
        ST_PEEL_EV  = 8'b0001_0000,
        ST_OUT_RD   = 8'b0010_0000,
        ST_OUT_LD   = 8'b0100_0000,
        ST_OUT_HOLD = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic accum;
        logic clear;
    } dom_ctrl_t;
endpackage
`default_nettype wire

[rtl/pfr_obj_mem.sv]
//------------------------------------------------------------------------------
// pfr_obj_mem: objective store
// One write port and two registered read ports, one per individual of a pair.
//------------------------------------------------------------------------------
`default_nettype none
module pfr_obj_mem
    import pfr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [OBJ_ADDR_W-1:0] waddr,
    input  wire logic [OBJ_W-1:0]      wdata,
    input  wire logic [OBJ_ADDR_W-1:0] raddr_a,
    input  wire logic [OBJ_ADDR_W-1:0] raddr_b,
    output logic      [OBJ_W-1:0]      rdata_a,
    output logic      [OBJ_W-1:0]      rdata_b
);
    logic [OBJ_W-1:0] mem [POP_MAX*OBJ_MAX];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire

[rtl/pfr_dom_unit.sv]
//------------------------------------------------------------------------------
// pfr_dom_unit: shared dominance compare unit
// Compares one objective of a pair per cycle and accumulates worse and better
// flags; dom reports whether a dominates b, including the current objective.
//------------------------------------------------------------------------------
`default_nettype none
module pfr_dom_unit
    import pfr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dom_ctrl_t        ctrl,
    input  wire logic [OBJ_W-1:0] val_a,
    input  wire logic [OBJ_W-1:0] val_b,
    output logic                  dom
);
    logic worse_reg, worse_next;
    logic better_reg, better_next;
    logic lt, gt;

    always_comb
    begin
        lt = $signed(val_a) < $signed(val_b);
        gt = $signed(val_a) > $signed(val_b);
        worse_next  = worse_reg | (ctrl.accum & gt);
        better_next = better_reg | (ctrl.accum & lt);
        dom = !worse_next && better_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worse_reg  <= 1'b0;
            better_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            worse_reg  <= 1'b0;
            better_reg <= 1'b0;
        end
        else
        begin
            worse_reg  <= worse_next;
            better_reg <= better_next;
        end
    end
endmodule
`default_nettype wire

[rtl/pareto_front_ranking.sv]
//------------------------------------------------------------------------------
// pareto_front_ranking: non-dominated sorting of a loaded population
// Loads objectives, compares every pair, peels fronts and emits one rank per
// individual in load order.
//------------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  objective_value, last_of_population
// result    out        out_valid / out_stall individual_index, front_rank,
//                                            last_result, overflow
// config    in         cfg_wr_en            cfg_wr_data (objective count)
//
// Loading writes one objective per accepted transaction; a short last individual
// is padded one missing objective at a time. Pair comparison runs on the single
// compare unit, then fronts are peeled and each result is held until taken. The
// input is stalled from the last transaction until the final result has been
// taken. Reset clears all control state; no clearing pass.
//------------------------------------------------------------------------------
`default_nettype none
module pareto_front_ranking
    import pfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [OBJ_W-1:0]     objective_value,
    input  wire logic                 last_of_population,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [POP_IDX_W-1:0] individual_index,
    output logic      [RANK_W-1:0]    front_rank,
    output logic                      last_result,
    output logic                      overflow
);
    state_t state_reg, state_next;
    logic [CFG_W-1:0]     cfg_reg;
    logic [OBJ_CNT_W-1:0] cnt;
    logic [POP_CNT_W-1:0] loaded_reg, loaded_next;
    logic [OBJ_IDX_W-1:0] pos_reg, pos_next, pos_eff;
    logic [OBJ_CNT_W-1:0] pos1;
    logic                 ovf_reg, ovf_next;
    logic [POP_IDX_W-1:0] n_last;
    logic                 room;

    logic [POP_IDX_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [OBJ_CNT_W-1:0] k_reg, k_next;
    logic [POP_MAX-1:0]   col_reg, col_next, col_wdata;
    logic [POP_MAX-1:0]   done_reg, done_next, front_reg, front_next;
    logic [RANK_W-1:0]    round_reg, round_next;
    logic [POP_CNT_W-1:0] ranked_reg, ranked_next;
    logic [POP_IDX_W-1:0] j_reg, j_next;

    logic                  obj_we;
    logic [OBJ_ADDR_W-1:0] obj_waddr, raddr_a, raddr_b;
    logic [OBJ_W-1:0]      obj_wdata, rdata_a, rdata_b;
    dom_ctrl_t             dctrl;
    logic                  dom;

    logic [POP_MAX-1:0]  col_mem [POP_MAX];
    logic [RANK_W-1:0]   rank_mem [POP_MAX];
    logic                col_we, rank_we;
    logic [POP_MAX-1:0]  col_q;
    logic [RANK_W-1:0]   rank_q;

    logic                 out_valid_reg, out_valid_next;
    logic [POP_IDX_W-1:0] out_idx_reg;
    logic [RANK_W-1:0]    out_rank_reg;
    logic                 out_last_reg, out_ovf_reg;
    logic                 in_acc, out_acc, front_hit;

    pfr_obj_mem u_obj_mem (
        .clk     (clk),
        .we      (obj_we),
        .waddr   (obj_waddr),
        .wdata   (obj_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    pfr_dom_unit u_dom_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dctrl),
        .val_a (rdata_a),
        .val_b (rdata_b),
        .dom   (dom)
    );

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            cnt = OBJ_CNT_W'(1);
        end
        else if ({1'b0, cfg_reg} > (CFG_W+1)'(OBJ_MAX))
        begin
            cnt = OBJ_CNT_W'(OBJ_MAX);
        end
        else
        begin
            cnt = OBJ_CNT_W'(cfg_reg);
        end
    end

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign room      = loaded_reg < POP_CNT_W'(POP_MAX);
    assign n_last    = POP_IDX_W'(loaded_reg - POP_CNT_W'(1));
    assign pos_eff   = ({1'b0, pos_reg} >= cnt) ? OBJ_IDX_W'(cnt - OBJ_CNT_W'(1)) : pos_reg;
    assign pos1      = {1'b0, pos_eff} + OBJ_CNT_W'(1);
    assign raddr_a   = {a_reg, k_reg[OBJ_IDX_W-1:0]};
    assign raddr_b   = {b_reg, k_reg[OBJ_IDX_W-1:0]};
    // A front member has no dominator left from earlier rounds.
    assign front_hit = !done_reg[j_reg] && ((col_q & ~done_reg) == '0);

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        pos_next       = pos_reg;
        ovf_next       = ovf_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        col_next       = col_reg;
        col_wdata      = col_reg;
        done_next      = done_reg;
        front_next     = front_reg;
        round_next     = round_reg;
        ranked_next    = ranked_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg;
        obj_we         = 1'b0;
        obj_waddr      = {loaded_reg[POP_IDX_W-1:0], pos_eff};
        obj_wdata      = objective_value;
        dctrl          = '0;
        col_we         = 1'b0;
        rank_we        = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    obj_we = room;
                    if (last_of_population && room && (pos1 < cnt))
                    begin
                        pos_next   = OBJ_IDX_W'(pos1);
                        state_next = ST_FILL;
                    end
                    else if (last_of_population || (pos1 >= cnt))
                    begin
                        pos_next = '0;
                        if (room)
                        begin
                            loaded_next = loaded_reg + POP_CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (last_of_population)
                        begin
                            state_next = ST_CMP;
                            a_next     = '0;
                            b_next     = '0;
                            k_next     = '0;
                            col_next   = '0;
                        end
                    end
                    else
                    begin
                        pos_next = OBJ_IDX_W'(pos1);
                    end
                end
            end
            ST_FILL:
            begin
                // Missing objectives of a short final individual read as zero.
                obj_we    = 1'b1;
                obj_waddr = {loaded_reg[POP_IDX_W-1:0], pos_reg};
                obj_wdata = '0;
                if (({1'b0, pos_reg} + OBJ_CNT_W'(1)) >= cnt)
                begin
                    pos_next    = '0;
                    loaded_next = loaded_reg + POP_CNT_W'(1);
                    state_next  = ST_CMP;
                    a_next      = '0;
                    b_next      = '0;
                    k_next      = '0;
                    col_next    = '0;
                end
                else
                begin
                    pos_next = pos_reg + OBJ_IDX_W'(1);
                end
            end
            ST_CMP:
            begin
                // Read data for objective k-1 arrives while k is issued.
                dctrl.accum = (k_reg != '0);
                if (k_reg == cnt)
                begin
                    dctrl.clear     = 1'b1;
                    col_next[a_reg] = dom;
                    col_wdata       = col_next;
                    k_next          = '0;
                    if (a_reg == n_last)
                    begin
                        col_we   = 1'b1;
                        col_next = '0;
                        a_next   = '0;
                        if (b_reg == n_last)
                        begin
                            state_next  = ST_PEEL_RD;
                            j_next      = '0;
                            round_next  = '0;
                            ranked_next = '0;
                            done_next   = '0;
                            front_next  = '0;
                        end
                        else
                        begin
                            b_next = b_reg + POP_IDX_W'(1);
                        end
                    end
                    else
                    begin
                        a_next = a_reg + POP_IDX_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + OBJ_CNT_W'(1);
                end
            end
            ST_PEEL_RD:
            begin
                state_next = ST_PEEL_EV;
            end
            ST_PEEL_EV:
            begin
                if (front_hit)
                begin
                    rank_we           = 1'b1;
                    front_next[j_reg] = 1'b1;
                    ranked_next       = ranked_reg + POP_CNT_W'(1);
                end
                if (j_reg == n_last)
                begin
                    done_next  = done_reg | front_next;
                    front_next = '0;
                    round_next = round_reg + RANK_W'(1);
                    j_next     = '0;
                    state_next = (ranked_next == loaded_reg) ? ST_OUT_RD : ST_PEEL_RD;
                end
                else
                begin
                    j_next     = j_reg + POP_IDX_W'(1);
                    state_next = ST_PEEL_RD;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_OUT_HOLD;
            end
            ST_OUT_HOLD:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (j_reg == n_last)
                    begin
                        loaded_next = '0;
                        pos_next    = '0;
                        ovf_next    = 1'b0;
                        state_next  = ST_LOAD;
                    end
                    else
                    begin
                        j_next     = j_reg + POP_IDX_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cfg_reg       <= CFG_RESET;
            loaded_reg    <= '0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            done_reg      <= '0;
            front_reg     <= '0;
            round_reg     <= '0;
            ranked_reg    <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            k_reg         <= k_next;
            done_reg      <= done_next;
            front_reg     <= front_next;
            round_reg     <= round_next;
            ranked_reg    <= ranked_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    // Column b of the dominance matrix: bit a set when a dominates b.
    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        if (col_we)
        begin
            col_mem[b_reg] <= col_wdata;
        end
        col_q <= col_mem[j_reg];
        if (rank_we)
        begin
            rank_mem[j_reg] <= round_reg;
        end
        rank_q <= rank_mem[j_reg];
        if (state_reg == ST_OUT_LD)
        begin
            out_idx_reg  <= j_reg;
            out_rank_reg <= rank_q;
            out_last_reg <= (j_reg == n_last);
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign individual_index = out_idx_reg;
    assign front_rank       = out_rank_reg;
    assign last_result      = out_last_reg;
    assign overflow         = out_ovf_reg;
endmodule
`default_nettype wire

[tb/tb_top.sv]
//------------------------------------------------------------------------------
// tb_top: testbench for pareto_front_ranking
// Loads populations of random and structured objectives, predicts the front of
// every individual with a software non-dominated sort and checks each emitted
// rank in order, under random idling and stalling on both channels.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

class rank_scoreboard;
    typedef struct {
        logic [5:0] index;
        logic [5:0] rank;
        logic       last;
        logic       ovf;
    } rank_rec_t;

    rank_rec_t   pending[$];
    logic [31:0] obj_mem[64][8];
    int          pop_count;
    int          obj_pos;
    bit          ovf_seen;
    int          obj_cfg;
    int          errors;

    function void reset_state();
        pending.delete();
        pop_count = 0;
        obj_pos = 0;
        ovf_seen = 0;
        obj_cfg = 2;
        errors = 0;
    endfunction

    function int active_objs();
        if (obj_cfg == 0)
            return 1;
        if (obj_cfg > 8)
            return 8;
        return obj_cfg;
    endfunction

    function bit beats(int a, int b, int c);
        bit better;
        better = 0;
        for (int k = 0; k < c; k++)
        begin
            if ($signed(obj_mem[a][k]) > $signed(obj_mem[b][k]))
                return 0;
            if ($signed(obj_mem[a][k]) < $signed(obj_mem[b][k]))
                better = 1;
        end
        return better;
    endfunction

    function void close_one();
        if (pop_count < 64)
            pop_count++;
        else
            ovf_seen = 1;
        obj_pos = 0;
    endfunction

    // Note one accepted input transaction; the last one yields the whole ranking.
    function void note_objective(logic [31:0] value, bit last);
        int c;
        int n;
        int ranked;
        bit dom[64][64];
        int cnt[64];
        int rk[64];
        bit done[64];
        bit front[64];
        rank_rec_t r;
        c = active_objs();
        if (obj_pos >= c)
            obj_pos = c - 1;
        if (pop_count < 64)
            obj_mem[pop_count][obj_pos] = value;
        obj_pos++;
        if (!last)
        begin
            if (obj_pos >= c)
                close_one();
            return;
        end
        if (pop_count < 64)
            for (int j = obj_pos; j < c; j++)
                obj_mem[pop_count][j] = '0;
        close_one();
        n = pop_count;
        for (int i = 0; i < n; i++)
        begin
            cnt[i] = 0;
            rk[i] = 0;
            done[i] = 0;
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                dom[i][j] = (i != j) && beats(i, j, c);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (dom[j][i])
                    cnt[i]++;
        ranked = 0;
        for (int rnd = 0; rnd < n && ranked < n; rnd++)
        begin
            for (int i = 0; i < n; i++)
            begin
                front[i] = !done[i] && cnt[i] == 0;
                if (front[i])
                begin
                    done[i] = 1;
                    rk[i] = rnd;
                    ranked++;
                end
            end
            for (int i = 0; i < n; i++)
                if (front[i])
                    for (int j = 0; j < n; j++)
                        if (dom[i][j] && cnt[j] > 0)
                            cnt[j]--;
        end
        for (int i = 0; i < n; i++)
        begin
            r.index = i[5:0];
            r.rank = rk[i][5:0];
            r.last = (i + 1 == n);
            r.ovf = ovf_seen;
            pending.push_back(r);
        end
        pop_count = 0;
        obj_pos = 0;
        ovf_seen = 0;
    endfunction

    function void check_rank(logic [5:0] idx, logic [5:0] rank, logic last, logic ovf);
        rank_rec_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result: individual_index %0d", idx);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (idx !== e.index)
        begin
            $error("individual_index: expected %0d, got %0d", e.index, idx);
            errors++;
        end
        if (rank !== e.rank)
        begin
            $error("front_rank: expected %0d, got %0d", e.rank, rank);
            errors++;
        end
        if (last !== e.last)
        begin
            $error("last_result: expected %0d, got %0d", e.last, last);
            errors++;
        end
        if (ovf !== e.ovf)
        begin
            $error("overflow: expected %0d, got %0d", e.ovf, ovf);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import pfr_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [OBJ_W-1:0]     objective_value;
    logic                 last_of_population;
    logic                 out_valid;
    logic                 out_stall;
    logic [POP_IDX_W-1:0] individual_index;
    logic [RANK_W-1:0]    front_rank;
    logic                 last_result;
    logic                 overflow;

    rank_scoreboard ranks;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int items_sent;

    pareto_front_ranking dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .objective_value    (objective_value),
        .last_of_population (last_of_population),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .individual_index   (individual_index),
        .front_rank         (front_rank),
        .last_result        (last_result),
        .overflow           (overflow)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1;
                hold_cycles--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            ranks.check_rank(individual_index, front_rank, last_result, overflow);

    // Valid stays high after a transaction so that items can follow back to back.
    task automatic send_objective(logic [31:0] value, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        objective_value <= value;
        last_of_population <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ranks.note_objective(value, last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (ranks.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_count(int value);
        wait_drained();
        cfg_wr_en <= 1;
        cfg_wr_data <= value[CFG_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 0;
        ranks.obj_cfg = value;
    endtask

    function automatic logic [31:0] pick_value(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(6)) - 3);
            default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    // A well-formed population of n individuals with random content.
    task automatic send_population(int n, int mode);
        int c;
        c = ranks.active_objs();
        for (int i = 0; i < n; i++)
            for (int k = 0; k < c; k++)
                send_objective(pick_value(mode), (i == n - 1) && (k == c - 1));
    endtask

    initial
    begin
        ranks = new();
        ranks.reset_state();
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        in_valid = 0;
        objective_value = '0;
        last_of_population = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: extremes, ties, a single individual and a short last one.
        send_objective(32'h8000_0000, 0);
        send_objective(32'h7FFF_FFFF, 0);
        send_objective(32'h7FFF_FFFF, 0);
        send_objective(32'h8000_0000, 0);
        send_objective(32'h0000_0000, 0);
        send_objective(32'h0000_0000, 0);
        send_objective(32'h0000_0000, 0);
        send_objective(32'h0000_0000, 0);
        send_objective(32'hFFFF_FFFF, 1);
        write_count(0);
        send_objective(32'h0000_0001, 1);
        send_objective(32'h0000_0005, 0);
        send_objective(32'hFFFF_FFFB, 1);
        write_count(15);
        send_population(2, 1);
        write_count(8);
        send_objective(32'h1234_5678, 0);
        send_objective(32'h0000_0001, 1);
        // A count changed in the middle of an individual.
        send_objective(32'h0000_0003, 0);
        send_objective(32'h0000_0002, 0);
        send_objective(32'h0000_0001, 0);
        write_count(2);
        send_objective(32'h0000_0004, 0);
        send_objective(32'h0000_0000, 1);

        // Overflow: 66 individuals of one objective.
        write_count(1);
        send_population(66, 1);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 49 : 37) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 49 : 37) : 0;
            write_count(phase == 0 ? 3 : (phase == 1 ? 2 : (phase == 2 ? 4 : 1)));
            while (items_sent < 100 + 20 * (phase + 1))
                send_population($urandom_range(2, 10), $urandom_range(2));
        end

        // Long receiver hold-off that outlasts the ranking of a full population,
        // so the next population is left waiting at the stalled input.
        write_count(1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 20000;
        send_population(64, 1);
        send_population(3, 0);
        wait_drained();

        if (ranks.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
